@@ hw/rtl/sid_pkg.sv @@
`timescale 1ns / 1ps

package sid_pkg;

  // status codes
  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_TRUNCATED = 2'd1;
  localparam logic [1:0] ST_UNKNOWN   = 2'd2;

  // format codes
  localparam logic [3:0] FMT_ALU3    = 4'd0;
  localparam logic [3:0] FMT_ALU2    = 4'd1;
  localparam logic [3:0] FMT_ALU1    = 4'd2;
  localparam logic [3:0] FMT_ISETP   = 4'd3;
  localparam logic [3:0] FMT_FSETP   = 4'd4;
  localparam logic [3:0] FMT_LOAD    = 4'd5;
  localparam logic [3:0] FMT_STORE   = 4'd6;
  localparam logic [3:0] FMT_TEXTURE = 4'd7;
  localparam logic [3:0] FMT_S2R     = 4'd8;
  localparam logic [3:0] FMT_PREDREG = 4'd9;
  localparam logic [3:0] FMT_EXIT    = 4'd10;
  localparam logic [3:0] FMT_BRANCH  = 4'd11;
  localparam logic [3:0] FMT_SYNC    = 4'd12;
  localparam logic [3:0] FMT_UNKNOWN = 4'd13;

  localparam logic [6:0] OP_NOP  = 7'd64;
  localparam logic [7:0] ID_MUFU = 8'h06;

  // memory space codes
  localparam logic [2:0] SPACE_GENERIC = 3'd4;

  // instruction sizes in bytes
  localparam logic [4:0] SIZE_SHORT = 5'd8;
  localparam logic [4:0] SIZE_LONG  = 5'd16;

  localparam int IN_W  = 160;
  localparam int OUT_W = 120;

  typedef struct packed {
    logic [1:0]  status;
    logic [3:0]  format_code;
    logic [6:0]  opcode_code;
    logic [4:0]  inst_size;
    logic [6:0]  dest_reg;
    logic [6:0]  src0_reg;
    logic [6:0]  src1_reg;
    logic [6:0]  src2_reg;
    logic [5:0]  pred_pair;
    logic [6:0]  flag_bits;
    logic [26:0] aux_bits;
    logic [31:0] jump_target;
  } sid_result_t;

  // format of an opcode id, unknown for unlisted ids
  function automatic logic [3:0] fmt_of_id(input logic [7:0] id);
    logic [3:0] f;
    f = FMT_UNKNOWN;
    case (id)
      8'h00, 8'h10, 8'h11, 8'h73, 8'h74, 8'h75:                  f = FMT_ALU3;
      8'h01, 8'h02, 8'h03, 8'h04, 8'h05,
      8'h12, 8'h13, 8'h14, 8'h15, 8'h16,
      8'h18, 8'h19, 8'h1A, 8'h1B,
      8'h20, 8'h21, 8'h22, 8'h31:                                f = FMT_ALU2;
      8'h06, 8'h07, 8'h08, 8'h09, 8'h0A, 8'h0B, 8'h0C, 8'h0D,
      8'h1C, 8'h1D, 8'h1E, 8'h1F:                                f = FMT_ALU1;
      8'h17:                                                     f = FMT_ISETP;
      8'h30:                                                     f = FMT_FSETP;
      8'h40, 8'h41, 8'h42, 8'h43, 8'h44:                         f = FMT_LOAD;
      8'h50, 8'h51, 8'h52, 8'h53:                                f = FMT_STORE;
      8'h60, 8'h61, 8'h62, 8'h63, 8'h64:                         f = FMT_TEXTURE;
      8'h70:                                                     f = FMT_S2R;
      8'h71, 8'h72:                                              f = FMT_PREDREG;
      8'h80, 8'h85, 8'h86, 8'h87, 8'h88:                         f = FMT_EXIT;
      8'h81, 8'h82:                                              f = FMT_BRANCH;
      8'h83, 8'h84:                                              f = FMT_SYNC;
      default:                                                   f = FMT_UNKNOWN;
    endcase
    return f;
  endfunction

  // dense opcode number: rank of the id among the listed ids
  function automatic logic [6:0] op_of_id(input logic [7:0] id);
    logic [6:0] lo;
    logic [6:0] op;
    lo = id[6:0];
    op = OP_NOP;
    if (id <= 8'h0D)                       op = lo;
    else if (id >= 8'h10 && id <= 8'h22)   op = lo - 7'h10 + 7'd14;
    else if (id >= 8'h30 && id <= 8'h31)   op = lo - 7'h30 + 7'd33;
    else if (id >= 8'h40 && id <= 8'h44)   op = lo - 7'h40 + 7'd35;
    else if (id >= 8'h50 && id <= 8'h53)   op = lo - 7'h50 + 7'd40;
    else if (id >= 8'h60 && id <= 8'h64)   op = lo - 7'h60 + 7'd44;
    else if (id >= 8'h70 && id <= 8'h75)   op = lo - 7'h70 + 7'd49;
    else if (id >= 8'h80 && id <= 8'h88)   op = (id[6:0] - 7'h00) + 7'd55;
    return op;
  endfunction

endpackage

@@ hw/rtl/sid_decode.sv @@
`timescale 1ns / 1ps

module sid_decode import sid_pkg::*; (
  input  logic [63:0]  word0,
  input  logic [63:0]  word1,
  input  logic [31:0]  pc,
  input  logic [31:0]  prog_len,
  output sid_result_t  result
);

  logic [32:0] end8;
  logic [32:0] end16;
  logic        truncated;
  logic [63:0] w1;
  logic [7:0]  id;
  logic [3:0]  fmt;
  logic [2:0]  space;
  logic [31:0] offset;

  // bounds against the program length, no wrap
  assign end8      = {1'b0, pc} + 33'd8;
  assign end16     = {1'b0, pc} + 33'd16;
  assign truncated = end8 > {1'b0, prog_len};
  assign w1        = (end16 > {1'b0, prog_len}) ? 64'd0 : word1;

  assign id  = word0[12:5];
  assign fmt = fmt_of_id(id);

  // memory space, raw codes above generic fold onto generic
  assign space  = (w1[47:45] > SPACE_GENERIC) ? SPACE_GENERIC : w1[47:45];
  // branch offset in 8-byte units, sign extended
  assign offset = {{15{word0[26]}}, word0[26:13], 3'b000};

  always_comb begin
    result             = '0;
    result.status      = ST_OK;
    result.format_code = fmt;
    result.opcode_code = op_of_id(id);
    result.inst_size   = SIZE_SHORT;
    unique case (fmt)
      FMT_ALU3, FMT_ALU2, FMT_ALU1: begin
        result.src0_reg     = word0[19:13];
        result.dest_reg     = {1'b0, word0[44:39]};
        result.flag_bits[5] = 1'b1;
        if (fmt != FMT_ALU1) begin
          result.src1_reg     = word0[26:20];
          result.flag_bits[0] = word0[45];
          result.flag_bits[1] = word0[46];
          result.flag_bits[2] = word0[47];
          result.flag_bits[4] = word0[49];
        end
        if (fmt == FMT_ALU3) begin
          result.src2_reg     = word0[33:27];
          result.flag_bits[3] = word0[48];
        end
        if (fmt == FMT_ALU1 && id == ID_MUFU) begin
          result.aux_bits[26:23] = word0[54:51];
        end
      end
      FMT_ISETP, FMT_FSETP: begin
        result.src0_reg     = word0[19:13];
        result.src1_reg     = word0[26:20];
        result.pred_pair    = {word0[42:40], word0[35:33]};
        result.flag_bits[0] = word0[45];
        result.flag_bits[1] = word0[46];
        result.flag_bits[5] = (fmt == FMT_FSETP);
        result.flag_bits[6] = 1'b1;
      end
      FMT_LOAD, FMT_STORE: begin
        result.inst_size      = SIZE_LONG;
        result.dest_reg       = word0[19:13];
        result.src0_reg       = {1'b0, word0[44:39]};
        result.aux_bits[7:0]  = word0[34:27];
        result.aux_bits[10:8] = space;
      end
      FMT_TEXTURE: begin
        result.inst_size       = SIZE_LONG;
        result.dest_reg        = word0[19:13];
        result.src0_reg        = word0[33:27];
        result.aux_bits[16:11] = word0[44:39];
        result.aux_bits[22:17] = w1[49:44];
      end
      FMT_S2R, FMT_PREDREG: begin
        result.dest_reg = word0[19:13];
        result.src0_reg = {1'b0, word0[44:39]};
      end
      FMT_BRANCH, FMT_SYNC: begin
        result.jump_target    = end8[31:0] + offset;
        result.pred_pair[2:0] = word0[35:33];
      end
      FMT_UNKNOWN: begin
        result.status = ST_UNKNOWN;
      end
      default: begin
      end
    endcase

    // truncated instruction clears everything but the status
    if (truncated) begin
      result        = '0;
      result.status = ST_TRUNCATED;
    end
  end

endmodule

@@ hw/rtl/shader_instruction_decoder_unit.sv @@
`timescale 1ns / 1ps

// Shader instruction decoder. Takes one instruction item per cycle (first
// word, second word, pc) and returns one decoded result item per input item,
// in order. Throughput is one item per clock while out_tready holds high;
// the input register and the result register lie around the single-pass
// decode (an opcode table lookup, field selection and one 32-bit branch add).
// The program length register must be written while no item is in flight;
// its reset value of 0 makes every instruction decode as truncated.
module shader_instruction_decoder_unit import sid_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cfg_we,
  input  logic [31:0]      cfg_wdata,
  input  logic             in_tvalid,
  output logic             in_tready,
  // word0 [63:0], word1 [127:64], pc [159:128]
  input  logic [IN_W-1:0]  in_tdata,
  output logic             out_tvalid,
  input  logic             out_tready,
  // status [1:0], format_code [5:2], opcode_code [12:6], inst_size [17:13],
  // dest_reg [24:18], src0_reg [31:25], src1_reg [38:32], src2_reg [45:39],
  // pred_pair [51:46], flag_bits [58:52], aux_bits [85:59],
  // jump_target [117:86], zero pad [119:118]
  output logic [OUT_W-1:0] out_tdata
);

  logic [31:0]  prog_len_r;
  logic         in_valid_r;
  logic [63:0]  word0_r;
  logic [63:0]  word1_r;
  logic [31:0]  pc_r;
  logic         out_valid_r;
  sid_result_t  res_r;
  sid_result_t  res_nxt;
  logic         advance;

  // configuration register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prog_len_r <= '0;
    end else if (cfg_we) begin
      prog_len_r <= cfg_wdata;
    end
  end

  // handshake: each stage moves when the one after it has room
  assign advance   = !out_valid_r || out_tready;
  assign in_tready = !in_valid_r || advance;

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_tready) begin
      in_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      word0_r <= in_tdata[63:0];
      word1_r <= in_tdata[127:64];
      pc_r    <= in_tdata[159:128];
    end
  end

  sid_decode u_decode (
    .word0    (word0_r),
    .word1    (word1_r),
    .pc       (pc_r),
    .prog_len (prog_len_r),
    .result   (res_nxt)
  );

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= in_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && in_valid_r) begin
      res_r <= res_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {2'b00,
                       res_r.jump_target,
                       res_r.aux_bits,
                       res_r.flag_bits,
                       res_r.pred_pair,
                       res_r.src2_reg,
                       res_r.src1_reg,
                       res_r.src0_reg,
                       res_r.dest_reg,
                       res_r.inst_size,
                       res_r.opcode_code,
                       res_r.format_code,
                       res_r.status};

endmodule
